// ===== rtl/ssic_pkg.sv =====
// ----------------------------------------------------------------------------
// ssic_pkg
// Shared widths and types for the square shell index to coordinates unit.
// ----------------------------------------------------------------------------
package ssic_pkg;

    // Result bits of the integer square root
    localparam int ROOT_BITS = 25;
    // Position width: two radicand bits are consumed per root bit
    localparam int POS_W     = 2 * ROOT_BITS;
    // Coordinate width: shell index is at most 2^ROOT_BITS
    localparam int COORD_W   = ROOT_BITS + 1;
    // Partial remainder width of the digit recurrence
    localparam int REM_W     = ROOT_BITS + 3;
    // Width of the shell square and corner index
    localparam int SQ_W      = POS_W + 1;
    // Iteration counter width
    localparam int CNT_W     = $clog2(ROOT_BITS + 1);

    // Status from the root unit to the sequencer
    typedef struct packed {
        logic done;    // one-cycle pulse, root and remainder are valid
        logic rem_nz;  // remainder nonzero: value is not a perfect square
    } t_root_stat;

endpackage

// ===== rtl/ssic_isqrt.sv =====
// ----------------------------------------------------------------------------
// ssic_isqrt
// Iterative floor square root, one result bit per cycle, MSB first,
// using the shift and subtract digit recurrence. Results hold until the
// next start.
// ----------------------------------------------------------------------------
module ssic_isqrt (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ssic_pkg::POS_W-1:0]      i_value,
    output logic [ssic_pkg::ROOT_BITS-1:0]  o_root,
    output logic [ssic_pkg::REM_W-1:0]      o_rem,
    output ssic_pkg::t_root_stat            o_stat
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                          r_state;
    logic [ssic_pkg::CNT_W-1:0]      r_cnt;
    logic [ssic_pkg::POS_W-1:0]      r_x;
    logic [ssic_pkg::ROOT_BITS-1:0]  r_root;
    logic [ssic_pkg::REM_W-1:0]      r_rem;
    logic                            r_done;

    logic [ssic_pkg::REM_W-1:0]      n_shifted;
    logic [ssic_pkg::REM_W-1:0]      n_trial;
    logic [ssic_pkg::REM_W-1:0]      n_diff;
    logic                            n_take;

    // One digit step: bring down two radicand bits, try subtracting 4r+1
    always_comb begin
        n_shifted = {r_rem[ssic_pkg::REM_W-3:0], r_x[ssic_pkg::POS_W-1 -: 2]};
        n_trial   = {1'b0, r_root, 2'b01};
        n_diff    = n_shifted - n_trial;
        n_take    = (n_shifted >= n_trial);
    end

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_value;
                        r_root  <= '0;
                        r_rem   <= '0;
                        r_cnt   <= ssic_pkg::CNT_W'(ssic_pkg::ROOT_BITS - 1);
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_x    <= {r_x[ssic_pkg::POS_W-3:0], 2'b00};
                    r_root <= {r_root[ssic_pkg::ROOT_BITS-2:0], n_take};
                    r_rem  <= n_take ? n_diff : n_shifted;
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_root        = r_root;
    assign o_rem         = r_rem;
    assign o_stat.done   = r_done;
    assign o_stat.rem_nz = (r_rem != '0);

endmodule

// ===== rtl/square_shell_index_to_coords_unit.sv =====
// ----------------------------------------------------------------------------
// square_shell_index_to_coords_unit
// Maps a one-based position in a zigzag shell-filled grid to column and row.
// ----------------------------------------------------------------------------
// One position is taken when start is high and busy is low. The result
// appears on o_column and o_row, where it holds until the next result,
// with o_valid high for exactly one cycle. After the transfer the unit
// passes a load state, the bit-serial square root unit (one root bit per
// cycle), and 5 sequencer steps that form the shell square, corner index,
// distance and coordinates. The receiver cannot stall; busy is low again in
// the cycle that o_valid is high, so a new start may be given then.
module square_shell_index_to_coords_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [ssic_pkg::POS_W-1:0]    i_position,
    output logic                          busy,
    output logic                          o_valid,
    output logic [ssic_pkg::COORD_W-1:0]  o_column,
    output logic [ssic_pkg::COORD_W-1:0]  o_row
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ROOT,
        S_SQUARE,
        S_CORNER,
        S_DIST,
        S_OUT
    } t_state;

    t_state                             r_state;
    logic [ssic_pkg::POS_W-1:0]         r_n;
    logic [ssic_pkg::COORD_W-1:0]       r_m;
    logic [ssic_pkg::POS_W-1:0]         r_sq;
    logic [ssic_pkg::SQ_W-1:0]          r_mm;
    logic [ssic_pkg::SQ_W-1:0]          r_c;
    logic [ssic_pkg::SQ_W-1:0]          r_d;
    logic                               r_upper;
    logic                               r_valid;
    logic [ssic_pkg::COORD_W-1:0]       r_col;
    logic [ssic_pkg::COORD_W-1:0]       r_row;

    logic [ssic_pkg::ROOT_BITS-1:0]     root;
    logic [ssic_pkg::REM_W-1:0]         rem;
    ssic_pkg::t_root_stat               root_stat;

    logic [ssic_pkg::SQ_W-1:0]          n_ext;
    logic [ssic_pkg::COORD_W-1:0]       n_md;

    // Bit-serial root unit
    ssic_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LOAD),
        .i_value (r_n),
        .o_root  (root),
        .o_rem   (rem),
        .o_stat  (root_stat)
    );

    assign n_ext = {1'b0, r_n};
    assign n_md  = r_m - r_d[ssic_pkg::COORD_W-1:0];

    // Sequencer: root, ceiling fix, square, corner, distance, coordinates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_n     <= i_position;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: r_state <= S_ROOT;
                S_ROOT: begin
                    // ceiling root, and floor root squared = n - remainder
                    if (root_stat.done) begin
                        r_m     <= {1'b0, root} + {{ssic_pkg::ROOT_BITS{1'b0}},
                                                   root_stat.rem_nz};
                        r_sq    <= r_n - ssic_pkg::POS_W'(rem);
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    // (r+1)^2 = r^2 + 2r + 1; position zero takes shell one
                    if (r_m == '0) begin
                        r_m  <= ssic_pkg::COORD_W'(1);
                        r_mm <= ssic_pkg::SQ_W'(1);
                    end else if (root_stat.rem_nz) begin
                        r_mm <= {1'b0, r_sq}
                              + {{(ssic_pkg::SQ_W - ssic_pkg::ROOT_BITS - 1){1'b0}},
                                 root, 1'b1};
                    end else begin
                        r_mm <= {1'b0, r_sq};
                    end
                    r_state <= S_CORNER;
                end
                S_CORNER: begin
                    r_c <= r_mm - {{(ssic_pkg::SQ_W - ssic_pkg::COORD_W){1'b0}}, r_m}
                         + ssic_pkg::SQ_W'(1);
                    r_state <= S_DIST;
                end
                S_DIST: begin
                    r_upper <= (n_ext >= r_c);
                    r_d     <= (n_ext >= r_c) ? (n_ext - r_c) : (r_c - n_ext);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // direction flips with shell parity
                    if (r_upper != r_m[0]) begin
                        r_col <= r_m;
                        r_row <= n_md;
                    end else begin
                        r_col <= n_md;
                        r_row <= r_m;
                    end
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_column = r_col;
    assign o_row    = r_row;

    // Accepted transfer makes the unit busy next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer accepted but unit not busy");

    // Result strobe only when the sequencer has returned to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // Result strobe lasts one cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // Root completion only while the sequencer waits for it
    a_root_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        root_stat.done |-> (r_state == S_ROOT))
        else $error("root done outside root wait");

endmodule

// ===== bench/square_shell_index_to_coords_unit_tb.sv =====
// ----------------------------------------------------------------------------
// square_shell_index_to_coords_unit_tb
// Self-checking bench: positions in, column and row out, compared against
// a behavioral shell-index predictor kept in a small scoreboard class.
// Edge positions first, then random shells, squares and corner indexes,
// with random idle bursts on the sender side.
// ----------------------------------------------------------------------------
module square_shell_index_to_coords_unit_tb;

    localparam int RANDOM_ITEMS = 1550;
    localparam int QUIET_TAIL   = 200;   // last items sent with no idling
    localparam int DRAIN_AT     = 700;   // random item after which we drain
    localparam int END_WAIT     = 40;    // extra wait after the final drain
    localparam int CYCLE_LIMIT  = 500000;
    localparam int MAX_PRINTS   = 32;

    localparam logic [ssic_pkg::POS_W-1:0] EDGE_POSITIONS [23] = '{
        50'h0,                    // zero position
        50'h1, 50'h2, 50'h3, 50'h4,
        50'h5, 50'h7, 50'h9, 50'hA,
        50'hC, 50'hD, 50'hE, 50'h10,
        50'h3_FFFF_FFFF_FFFF,     // largest position
        50'h3_FFFF_FFFF_FFFE,
        50'h3_FFFF_FE00_0001,     // corner of the top shell
        50'h3_FFFF_FE00_0000,
        50'h3_FFFF_FC00_0001,     // square of 2^25-1
        50'h3_FFFF_FC00_0002,
        50'h1_0000_0000_0000,
        50'h2_0000_0000_0001,
        50'h2_AAAA_AAAA_AAAA,
        50'h1_5555_5555_5555
    };

    typedef struct packed {
        logic [ssic_pkg::POS_W-1:0]   position;
        logic [ssic_pkg::COORD_W-1:0] column;
        logic [ssic_pkg::COORD_W-1:0] row;
    } t_shell_coord;

    // Scoreboard: predicts coordinates per accepted position, checks results
    class t_shell_coord_board;
        t_shell_coord expected_coords[$];
        int           mismatches;
        int           checked;

        function new();
            mismatches = 0;
            checked    = 0;
        endfunction

        // Ceiling root via bit-serial floor root, then corner and distance
        function t_shell_coord predict_coords(logic [ssic_pkg::POS_W-1:0] pos);
            logic [63:0]  n, r, cand, m, c, d, col, row;
            bit           upper, odd;
            t_shell_coord res;
            n = 64'(pos);
            r = '0;
            for (int b = ssic_pkg::ROOT_BITS - 1; b >= 0; b--) begin
                cand = r | (64'd1 << b);
                if (cand * cand <= n) begin
                    r = cand;
                end
            end
            m = r;
            if (m * m < n) begin
                m = m + 64'd1;
            end
            // zero position falls into shell one
            if (m == 64'd0) begin
                m = 64'd1;
            end
            c     = m * m - m + 64'd1;
            upper = (n >= c);
            d     = upper ? (n - c) : (c - n);
            odd   = m[0];
            if (upper != odd) begin
                col = m;
                row = m - d;
            end else begin
                col = m - d;
                row = m;
            end
            res.position = pos;
            res.column   = col[ssic_pkg::COORD_W-1:0];
            res.row      = row[ssic_pkg::COORD_W-1:0];
            return res;
        endfunction

        function void note_position(logic [ssic_pkg::POS_W-1:0] pos);
            expected_coords.insert(expected_coords.size(), predict_coords(pos));
        endfunction

        function int pending();
            return expected_coords.size();
        endfunction

        task report(string what);
            if (mismatches < MAX_PRINTS) begin
                $display("MISMATCH: %s", what);
            end
            mismatches++;
        endtask

        task check_coords(logic [ssic_pkg::COORD_W-1:0] col,
                          logic [ssic_pkg::COORD_W-1:0] row);
            t_shell_coord exp;
            checked++;
            if (expected_coords.size() == 0) begin
                report($sformatf("result col=%0d row=%0d with no position pending",
                                 col, row));
            end else begin
                exp = expected_coords.pop_front();
                if (col !== exp.column) begin
                    report($sformatf("pos=%0d column got %0d want %0d",
                                     exp.position, col, exp.column));
                end
                if (row !== exp.row) begin
                    report($sformatf("pos=%0d row got %0d want %0d",
                                     exp.position, row, exp.row));
                end
            end
        endtask
    endclass

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         start      = 1'b0;
    logic [ssic_pkg::POS_W-1:0]   i_position = '0;
    logic                         busy;
    logic                         o_valid;
    logic [ssic_pkg::COORD_W-1:0] o_column;
    logic [ssic_pkg::COORD_W-1:0] o_row;

    t_shell_coord_board board = new();
    int                 positions_sent = 0;
    int                 cycle_count    = 0;

    square_shell_index_to_coords_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_position (i_position),
        .busy       (busy),
        .o_valid    (o_valid),
        .o_column   (o_column),
        .o_row      (o_row)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Monitor: input transfers and result strobes, sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            board.note_position(i_position);
            positions_sent++;
        end
        if (i_rst_n && o_valid) begin
            board.check_coords(o_column, o_row);
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL square_shell_index_to_coords_unit");
        $finish;
    end

    // Called at a rising edge; returns at the edge of the transfer.
    // A nonzero gap holds start low while busy and then for an idle burst set by gap.
    task automatic send_position(input logic [ssic_pkg::POS_W-1:0] pos, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            do @(posedge i_clk); while (busy);
            repeat (gap - 1) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_position <= pos;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Hold off until every pending result has come back
    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    // Gap of 1..16 for one idle burst, or none
    function automatic int pick_gap(bit quiet);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 16);
        end
        return gap;
    endfunction

    // Half small shells, half anywhere up to the top shell
    function automatic logic [63:0] pick_shell();
        if ($urandom_range(0, 1) != 0) begin
            return 64'($urandom_range(1, 64));
        end
        return 64'($urandom_range(1, 1 << ssic_pkg::ROOT_BITS));
    endfunction

    function automatic logic [ssic_pkg::POS_W-1:0] gen_position();
        logic [63:0] v, k;
        int          w;
        k = pick_shell();
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: begin
                w = $urandom_range(1, ssic_pkg::POS_W);
                v = {$urandom, $urandom} & ((64'd1 << w) - 64'd1);
            end
            // near a perfect square
            2: v = k * k + 64'($urandom_range(0, 6)) - 64'd3;
            // near a shell corner
            3: v = k * k - k + 64'd1 + 64'($urandom_range(0, 6)) - 64'd3;
            4: v = 64'($urandom_range(0, 1000));
            // anywhere inside shell k
            default: v = (k - 64'd1) * (k - 64'd1)
                         + 64'($urandom_range(1, 2 * k[31:0] - 1));
        endcase
        return v[ssic_pkg::POS_W-1:0];
    endfunction

    // Stimulus
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (EDGE_POSITIONS[i]) begin
            send_position(EDGE_POSITIONS[i], (i < 8) ? 0 : pick_gap(1'b0));
        end
        wait_for_results();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            send_position(gen_position(), pick_gap(i >= RANDOM_ITEMS - QUIET_TAIL));
            if (i == DRAIN_AT) begin
                wait_for_results();
            end
        end

        wait_for_results();
        repeat (END_WAIT) @(posedge i_clk);
        if (board.pending() != 0) begin
            board.report($sformatf("%0d results never arrived", board.pending()));
        end

        $display("Sent %0d positions (%0d edge cases, then random shells, squares,",
                 positions_sent, $size(EDGE_POSITIONS));
        $display("corners and full-width values); %0d results checked, %0d mismatches",
                 board.checked, board.mismatches);
        if (board.mismatches == 0) begin
            $display("PASS square_shell_index_to_coords_unit");
        end else begin
            $display("FAIL square_shell_index_to_coords_unit");
        end
        $finish;
    end

endmodule
